[src/rau_pkg.sv]
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and codes for the rational arithmetic unit: sequencer states,
// command codes and status codes.
// ----------------------------------------------------------------------------
package rau_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FORM,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_CHECK,
    ST_DONE
  } state_t;

  localparam logic [3:0] CMD_NORM = 4'd0;
  localparam logic [3:0] CMD_ADD  = 4'd1;
  localparam logic [3:0] CMD_SUB  = 4'd2;
  localparam logic [3:0] CMD_MUL  = 4'd3;
  localparam logic [3:0] CMD_DIV  = 4'd4;
  localparam logic [3:0] CMD_CMP  = 4'd5;
  localparam logic [3:0] CMD_INV  = 4'd6;
  localparam logic [3:0] CMD_INC  = 4'd7;
  localparam logic [3:0] CMD_DEC  = 4'd8;
  localparam logic [3:0] CMD_NEG  = 4'd9;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_DIV0 = 2'd1;
  localparam logic [1:0] STAT_OVF  = 2'd2;

endpackage

[src/rational_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Command-driven fraction arithmetic with GCD reduction on one shared
// multiplier, one shared subtract/compare GCD unit and one restoring divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries a command and fractions A, B.
//   Output channel (out_valid / out_stall) returns one reduced fraction, a
//   status code and the compare flags for each input transfer.
//   One item at a time: in_stall stays high from the input transfer until the
//   result has been taken. Steps from input transfer to result transfer:
//     error and unknown-command paths: check only; compare: products, form,
//     check; reducing paths: three products on the shared multiplier (add,
//     subtract, multiply, divide) or none, a forming step, then a binary GCD
//     of one compare and subtract or shift per cycle, then two 64-bit
//     restoring divisions (numerator, then denominator) and a check step.
//   The worst case is set by the GCD loop and the divider; the next input is
//   taken in the cycle after the result transfer.
//   Reset returns the sequencer to idle with no result pending. While the
//   receiver stalls, the result is held on the output ports and no new
//   input is taken.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         command,
  input  logic signed [31:0] a_num,
  input  logic signed [31:0] a_den,
  input  logic signed [31:0] b_num,
  input  logic [30:0]        b_den,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] res_num,
  output logic [30:0]        res_den,
  output logic [1:0]         status,
  output logic               is_less,
  output logic               is_equal
);

  localparam logic [63:0] LIM = 64'd1 << (VALUE_WIDTH - 1);

  // magnitude of a 32-bit two's complement value
  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (32'd0 - v) : v;
  endfunction

  // sign-magnitude add, result {sign, magnitude}
  function automatic logic [64:0] sm_add(input logic na, input logic [63:0] ma,
                                         input logic nb, input logic [63:0] mb);
    logic        nr;
    logic [63:0] mr;
    if (na == nb) begin
      nr = na;
      mr = ma + mb;
    end else if (ma >= mb) begin
      nr = na;
      mr = ma - mb;
    end else begin
      nr = nb;
      mr = mb - ma;
    end
    if (mr == 64'd0) nr = 1'b0;
    sm_add = {nr, mr};
  endfunction

  rau_pkg::state_t state, state_next;

  // operand registers
  logic [3:0]  cmd;
  logic [31:0] an, ad, bn;
  logic [30:0] bd;
  logic        a_neg, bn_neg;

  // working registers
  logic [63:0] prod [0:2];
  logic [1:0]  mul_idx;
  logic        neg;
  logic [63:0] num, den;
  logic [1:0]  st;
  logic        less, eq;
  logic [63:0] gx, gy, g;
  logic [5:0]  gk;
  logic [63:0] rem, quo;
  logic [5:0]  cnt;

  // input decode
  logic [31:0] in_an, in_ad, in_bn;
  logic        in_an_neg, in_ad_neg, in_bn_neg;
  logic        accept, early_done;
  logic [1:0]  early_st;

  always_comb begin
    in_an     = mag32(a_num);
    in_ad     = mag32(a_den);
    in_bn     = mag32(b_num);
    in_an_neg = a_num[31];
    in_ad_neg = a_den[31];
    in_bn_neg = b_num[31];
    accept    = in_valid && !in_stall;
    early_st  = rau_pkg::STAT_OK;
    early_done = 1'b0;
    if (command > rau_pkg::CMD_NEG) begin
      early_done = 1'b1;
    end else if (in_ad == 32'd0) begin
      early_done = 1'b1;
      early_st   = rau_pkg::STAT_DIV0;
    end else if (command >= rau_pkg::CMD_ADD && command <= rau_pkg::CMD_CMP &&
                 b_den == 31'd0) begin
      early_done = 1'b1;
      early_st   = rau_pkg::STAT_DIV0;
    end else if (command == rau_pkg::CMD_DIV && in_bn == 32'd0) begin
      early_done = 1'b1;
      early_st   = rau_pkg::STAT_DIV0;
    end else if (command == rau_pkg::CMD_INV && in_an == 32'd0) begin
      early_done = 1'b1;
      early_st   = rau_pkg::STAT_DIV0;
    end
  end

  // shared multiplier operand select
  logic [31:0] mul_x, mul_y;
  logic [63:0] mul_p;

  always_comb begin
    mul_x = an;
    mul_y = {1'b0, bd};
    case (cmd) inside
      rau_pkg::CMD_MUL: begin
        mul_x = (mul_idx == 2'd0) ? an : ad;
        mul_y = (mul_idx == 2'd0) ? bn : {1'b0, bd};
      end
      rau_pkg::CMD_DIV: begin
        mul_x = (mul_idx == 2'd0) ? an : ad;
        mul_y = (mul_idx == 2'd0) ? {1'b0, bd} : bn;
      end
      default: begin
        if (mul_idx == 2'd1) begin
          mul_x = bn;
          mul_y = ad;
        end else if (mul_idx == 2'd2) begin
          mul_x = ad;
          mul_y = {1'b0, bd};
        end
      end
    endcase
    mul_p = mul_x * mul_y;
  end

  // form the unreduced fraction from products or operands
  logic        f_neg, f_less, f_eq, f_nb, f_sl, f_sr;
  logic [63:0] f_num, f_den;
  logic [64:0] f_sum;

  always_comb begin
    f_neg  = 1'b0;
    f_num  = 64'd0;
    f_den  = 64'd1;
    f_less = 1'b0;
    f_eq   = 1'b0;
    f_nb   = (bn != 32'd0) && (bn_neg != (cmd == rau_pkg::CMD_SUB));
    f_sl   = a_neg && (prod[0] != 64'd0);
    f_sr   = bn_neg && (prod[1] != 64'd0);
    f_sum  = sm_add(a_neg, prod[0], f_nb, prod[1]);
    unique case (cmd) inside
      rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: begin
        f_neg = f_sum[64];
        f_num = f_sum[63:0];
        f_den = prod[2];
      end
      rau_pkg::CMD_MUL, rau_pkg::CMD_DIV: begin
        f_num = prod[0];
        f_den = prod[1];
        f_neg = (prod[0] != 64'd0) && (a_neg != bn_neg);
      end
      rau_pkg::CMD_CMP: begin
        if (f_sl != f_sr) f_less = f_sl;
        else if (!f_sl)   f_less = prod[0] < prod[1];
        else              f_less = prod[0] > prod[1];
        f_eq = (an == bn) && (a_neg == (bn_neg && bn != 32'd0)) &&
               (ad == {1'b0, bd});
      end
      rau_pkg::CMD_INV: begin
        f_neg = a_neg;
        f_num = {32'd0, ad};
        f_den = {32'd0, an};
      end
      rau_pkg::CMD_INC, rau_pkg::CMD_DEC: begin
        f_sum = sm_add(a_neg, {32'd0, an}, cmd == rau_pkg::CMD_DEC, {32'd0, ad});
        f_neg = f_sum[64];
        f_num = f_sum[63:0];
        f_den = {32'd0, ad};
      end
      rau_pkg::CMD_NEG: begin
        f_neg = (an != 32'd0) && !a_neg;
        f_num = {32'd0, an};
        f_den = {32'd0, ad};
      end
      rau_pkg::CMD_NORM: begin
        f_neg = a_neg;
        f_num = {32'd0, an};
        f_den = {32'd0, ad};
      end
      default: begin
        f_num = 64'd0;
      end
    endcase
  end

  // restoring divider step
  logic [64:0] d_sh;
  logic        d_ge;
  logic [63:0] d_rem, d_quo;

  always_comb begin
    d_sh  = {rem, quo[63]};
    d_ge  = d_sh >= {1'b0, g};
    d_rem = d_ge ? 64'(d_sh - {1'b0, g}) : d_sh[63:0];
    d_quo = {quo[62:0], d_ge};
  end

  // final range check
  logic [63:0] c_den;
  logic        c_ovf;

  always_comb begin
    c_den = (num == 64'd0) ? 64'd1 : den;
    c_ovf = (c_den > LIM - 64'd1) || (neg ? (num > LIM) : (num > LIM - 64'd1));
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rau_pkg::ST_IDLE: begin
        if (accept) begin
          if (early_done) state_next = rau_pkg::ST_CHECK;
          else if (command >= rau_pkg::CMD_ADD && command <= rau_pkg::CMD_CMP)
            state_next = rau_pkg::ST_MUL;
          else state_next = rau_pkg::ST_FORM;
        end
      end
      rau_pkg::ST_MUL: begin
        if (mul_idx == 2'd2) state_next = rau_pkg::ST_FORM;
      end
      rau_pkg::ST_FORM: begin
        if (cmd == rau_pkg::CMD_CMP || f_num == 64'd0) state_next = rau_pkg::ST_CHECK;
        else state_next = rau_pkg::ST_GCD;
      end
      rau_pkg::ST_GCD: begin
        if (gx == gy) state_next = rau_pkg::ST_DIVN;
      end
      rau_pkg::ST_DIVN: begin
        if (cnt == 6'd63) state_next = rau_pkg::ST_DIVD;
      end
      rau_pkg::ST_DIVD: begin
        if (cnt == 6'd63) state_next = rau_pkg::ST_CHECK;
      end
      rau_pkg::ST_CHECK: state_next = rau_pkg::ST_DONE;
      rau_pkg::ST_DONE: begin
        if (!out_stall) state_next = rau_pkg::ST_IDLE;
      end
      default: state_next = rau_pkg::ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall  = (state != rau_pkg::ST_IDLE);
    out_valid = (state == rau_pkg::ST_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= rau_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      rau_pkg::ST_IDLE: begin
        cmd     <= command;
        an      <= in_an;
        ad      <= in_ad;
        bn      <= in_bn;
        bd      <= b_den;
        a_neg   <= (in_an != 32'd0) && (in_an_neg != in_ad_neg);
        bn_neg  <= (in_an == 32'd0) ? (in_bn_neg && in_bn != 32'd0) : in_bn_neg;
        st      <= early_st;
        neg     <= 1'b0;
        num     <= 64'd0;
        den     <= 64'd1;
        less    <= 1'b0;
        eq      <= 1'b0;
        mul_idx <= 2'd0;
      end
      rau_pkg::ST_MUL: begin
        prod[mul_idx] <= mul_p;
        mul_idx       <= mul_idx + 2'd1;
      end
      rau_pkg::ST_FORM: begin
        neg  <= f_neg;
        num  <= f_num;
        den  <= f_den;
        less <= f_less;
        eq   <= f_eq;
        gx   <= f_num;
        gy   <= f_den;
        gk   <= 6'd0;
      end
      rau_pkg::ST_GCD: begin
        // binary GCD: one shift or one subtract per cycle
        if (gx == gy) begin
          g   <= gx << gk;
          rem <= 64'd0;
          quo <= num;
          cnt <= 6'd0;
        end else if (!gx[0] && !gy[0]) begin
          gx <= gx >> 1;
          gy <= gy >> 1;
          gk <= gk + 6'd1;
        end else if (!gx[0]) begin
          gx <= gx >> 1;
        end else if (!gy[0]) begin
          gy <= gy >> 1;
        end else if (gx > gy) begin
          gx <= gx - gy;
        end else begin
          gy <= gy - gx;
        end
      end
      rau_pkg::ST_DIVN: begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          num <= d_quo;
          rem <= 64'd0;
          quo <= den;
        end else begin
          rem <= d_rem;
          quo <= d_quo;
        end
      end
      rau_pkg::ST_DIVD: begin
        rem <= d_rem;
        quo <= d_quo;
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) den <= d_quo;
      end
      rau_pkg::ST_CHECK: begin
        is_less  <= less;
        is_equal <= eq;
        if (st != rau_pkg::STAT_OK || c_ovf) begin
          status  <= (st != rau_pkg::STAT_OK) ? st : rau_pkg::STAT_OVF;
          res_num <= 32'sd0;
          res_den <= 31'd1;
        end else begin
          status  <= rau_pkg::STAT_OK;
          res_num <= neg ? (32'sd0 - $signed(num[31:0])) : $signed(num[31:0]);
          res_den <= c_den[30:0];
        end
      end
      rau_pkg::ST_DONE: begin
        // hold result until transfer
      end
      default: begin
      end
    endcase
  end

endmodule

[tb/sv/rau_checker.sv]
// ----------------------------------------------------------------------------
// rau_checker
// Watches both channels of the rational arithmetic unit, predicts each
// reduced fraction, status and compare flag set, and compares in order.
// ----------------------------------------------------------------------------
module rau_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [3:0]         command,
  input  logic signed [31:0] a_num,
  input  logic signed [31:0] a_den,
  input  logic signed [31:0] b_num,
  input  logic [30:0]        b_den,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] res_num,
  input  logic [30:0]        res_den,
  input  logic [1:0]         status,
  input  logic               is_less,
  input  logic               is_equal,
  output int                 fail_count,
  output int                 pending_count
);

  typedef struct packed {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic [1:0]         stat;
    logic               less;
    logic               equal;
  } fraction_t;

  fraction_t expected_fractions[$];

  function automatic logic [63:0] gcd(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 64'd0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic logic [63:0] magnitude(logic [31:0] raw);
    return raw[31] ? 64'h1_0000_0000 - {32'd0, raw} : {32'd0, raw};
  endfunction

  // Reduce, range check and pack one result.
  function automatic fraction_t pack_result(logic neg, logic [63:0] num, logic [63:0] den,
                                            logic [1:0] stat, logic less, logic equal);
    fraction_t r;
    logic [63:0] g;
    if (stat == rau_pkg::STAT_OK) begin
      if (num == 64'd0) den = 64'd1;
      else begin
        g = gcd(num, den);
        num = num / g;
        den = den / g;
      end
      if (den > 64'h7FFF_FFFF || (neg ? num > 64'h8000_0000 : num > 64'h7FFF_FFFF))
        stat = rau_pkg::STAT_OVF;
    end
    if (stat != rau_pkg::STAT_OK) begin
      r.num = 32'sd0;
      r.den = 31'd1;
    end else begin
      r.num = neg ? -num[31:0] : num[31:0];
      r.den = den[30:0];
    end
    r.stat = stat;
    r.less = less;
    r.equal = equal;
    return r;
  endfunction

  // Zero fraction with a given status and no compare flags.
  function automatic fraction_t plain_result(logic [1:0] stat);
    return pack_result(1'b0, 64'd0, 64'd1, stat, 1'b0, 1'b0);
  endfunction

  // Signed-magnitude sum.
  function automatic void add_signed(logic na, logic [63:0] ma, logic nb, logic [63:0] mb,
                                     output logic nr, output logic [63:0] mr);
    if (na == nb) begin
      nr = na;
      mr = ma + mb;
    end else if (ma >= mb) begin
      nr = na;
      mr = ma - mb;
    end else begin
      nr = nb;
      mr = mb - ma;
    end
    if (mr == 64'd0) nr = 1'b0;
  endfunction

  function automatic fraction_t predict_fraction(logic [3:0] cmd, logic [31:0] an_raw,
                                                 logic [31:0] ad_raw, logic [31:0] bn_raw,
                                                 logic [30:0] bd_raw);
    logic [63:0] an, ad, bn, bd, rn, ml, mr;
    logic a_neg, bn_neg, r_neg, nb, sl, sr, less, equal;
    an = magnitude(an_raw);
    ad = magnitude(ad_raw);
    bn = magnitude(bn_raw);
    bd = {33'd0, bd_raw};
    bn_neg = bn_raw[31];
    a_neg = (an != 64'd0) && (an_raw[31] != ad_raw[31]);
    if (an == 64'd0) bn_neg = bn_neg && (bn != 64'd0);
    if (cmd > rau_pkg::CMD_NEG) return plain_result(rau_pkg::STAT_OK);
    if (ad == 64'd0) return plain_result(rau_pkg::STAT_DIV0);
    if (cmd >= rau_pkg::CMD_ADD && cmd <= rau_pkg::CMD_CMP && bd == 64'd0)
      return plain_result(rau_pkg::STAT_DIV0);
    case (cmd)
      rau_pkg::CMD_NORM: return pack_result(a_neg, an, ad, rau_pkg::STAT_OK, 1'b0, 1'b0);
      rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: begin
        nb = (bn != 64'd0) && (bn_neg != (cmd == rau_pkg::CMD_SUB));
        add_signed(a_neg, an * bd, nb, bn * ad, r_neg, rn);
        return pack_result(r_neg, rn, ad * bd, rau_pkg::STAT_OK, 1'b0, 1'b0);
      end
      rau_pkg::CMD_MUL: begin
        rn = an * bn;
        return pack_result((rn != 64'd0) && (a_neg != bn_neg), rn, ad * bd,
                           rau_pkg::STAT_OK, 1'b0, 1'b0);
      end
      rau_pkg::CMD_DIV: begin
        if (bn == 64'd0) return plain_result(rau_pkg::STAT_DIV0);
        rn = an * bd;
        return pack_result((rn != 64'd0) && (a_neg != bn_neg), rn, ad * bn,
                           rau_pkg::STAT_OK, 1'b0, 1'b0);
      end
      rau_pkg::CMD_CMP: begin
        ml = an * bd;
        mr = bn * ad;
        sl = a_neg && ml != 64'd0;
        sr = bn_neg && mr != 64'd0;
        if (sl != sr) less = sl;
        else if (!sl) less = ml < mr;
        else less = ml > mr;
        equal = (an == bn) && (a_neg == (bn_neg && bn != 64'd0)) && (ad == bd);
        return pack_result(1'b0, 64'd0, 64'd1, rau_pkg::STAT_OK, less, equal);
      end
      rau_pkg::CMD_INV: begin
        if (an == 64'd0) return plain_result(rau_pkg::STAT_DIV0);
        return pack_result(a_neg, ad, an, rau_pkg::STAT_OK, 1'b0, 1'b0);
      end
      rau_pkg::CMD_INC, rau_pkg::CMD_DEC: begin
        add_signed(a_neg, an, cmd == rau_pkg::CMD_DEC, ad, r_neg, rn);
        return pack_result(r_neg, rn, ad, rau_pkg::STAT_OK, 1'b0, 1'b0);
      end
      default: return pack_result((an != 64'd0) && !a_neg, an, ad, rau_pkg::STAT_OK,
                                  1'b0, 1'b0);
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  // Predict on input transfers; compare on output transfers.
  always @(posedge clk) begin
    fraction_t e;
    if (rst) begin
      fail_count = 0;
      pending_count <= 0;
    end else begin
      if (in_valid && !in_stall)
        expected_fractions.push_back(predict_fraction(command, a_num, a_den, b_num, b_den));
      if (out_valid && !out_stall) begin
        if (expected_fractions.size() == 0) begin
          report_mismatch("unexpected result", 64'd1, 64'd0);
        end else begin
          e = expected_fractions.pop_front();
          if (res_num !== e.num) report_mismatch("res_num", res_num, e.num);
          if (res_den !== e.den) report_mismatch("res_den", res_den, e.den);
          if (status !== e.stat) report_mismatch("status", status, e.stat);
          if (is_less !== e.less) report_mismatch("is_less", is_less, e.less);
          if (is_equal !== e.equal) report_mismatch("is_equal", is_equal, e.equal);
        end
      end
      pending_count <= expected_fractions.size();
    end
  end

endmodule

[tb/sv/rational_arithmetic_unit_test.sv]
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_test
// Drives directed and random commands with bursty input and a patterned
// output stall; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_test;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [3:0] command = rau_pkg::CMD_NORM;
  logic signed [31:0] a_num = 0;
  logic signed [31:0] a_den = 1;
  logic signed [31:0] b_num = 0;
  logic [30:0] b_den = 31'd1;
  logic out_valid;
  logic out_stall = 0;
  logic signed [31:0] res_num;
  logic [30:0] res_den;
  logic [1:0] status;
  logic is_less, is_equal;
  int fail_count, pending_count;
  int cycle_count = 0;
  int stall_phase = 0;

  localparam int CYCLE_LIMIT = 3_000_000;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  rational_arithmetic_unit dut (.*);

  rau_checker checker_inst (.*);

  // Stall the receiver in patterned stretches, with quiet spans between.
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase[11:10] == 2'd3) out_stall <= 0;
    else if (stall_phase[9]) out_stall <= ($urandom_range(0, 3) == 0);
    else out_stall <= (stall_phase[3:0] < 4'd5);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [31:0] pick_value(bit small_range);
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 0;
      3: return $urandom;
      default: return small_range ? $urandom_range(0, 60) - 30 : $urandom_range(0, 2000) - 1000;
    endcase
  endfunction

  // Present one item and hold it until the transfer.
  task automatic send(logic [3:0] cmd, logic [31:0] an, logic [31:0] ad, logic [31:0] bn,
                      logic [31:0] bd);
    command <= cmd;
    a_num <= an;
    a_den <= ad;
    b_num <= bn;
    b_den <= bd[30:0];
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random();
    logic [3:0] cmd;
    logic [31:0] ad;
    logic [31:0] bd;
    bit sm;
    sm = 1'($urandom_range(0, 1));
    cmd = ($urandom_range(0, 20) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
    ad = pick_value(sm);
    bd = ($urandom_range(0, 15) == 0) ? 0 : (sm ? $urandom_range(1, 40) : $urandom);
    if ($urandom_range(0, 15) != 0 && ad == 0) ad = 1;
    send(cmd, pick_value(sm), ad, pick_value(sm), bd);
  endtask

  initial begin
    int burst;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: every command, field extremes and error cases.
    for (int c = 0; c <= 9; c++) send(4'(c), 6, -4, -9, 15);
    send(rau_pkg::CMD_NORM, 32'h8000_0000, -1, 0, 1);
    send(rau_pkg::CMD_ADD, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1);
    send(rau_pkg::CMD_MUL, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send(rau_pkg::CMD_ADD, 1, 0, 1, 1);
    send(rau_pkg::CMD_SUB, 1, 2, 1, 0);
    send(rau_pkg::CMD_DIV, 3, 4, 0, 5);
    send(rau_pkg::CMD_INV, 0, 7, 1, 1);
    send(rau_pkg::CMD_CMP, 3, 6, 1, 2);
    send(rau_pkg::CMD_CMP, -1, 3, 0, 1);
    send(rau_pkg::CMD_CMP, 1, 2, 1, 0);
    send(rau_pkg::CMD_INC, -1, 1, 0, 1);
    send(rau_pkg::CMD_DEC, 32'h8000_0000, 1, 0, 1);
    send(rau_pkg::CMD_NEG, 32'h8000_0000, 1, 0, 1);
    send(4'd15, -1, -1, -1, 32'h7FFF_FFFF);

    // Let everything drain once.
    in_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);

    // Random bursts with random gaps.
    for (int n = 0; n < 1450; n += burst) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst; k++) send_random();
      in_valid <= 0;
      repeat ($urandom_range(0, 6)) @(posedge clk);
    end

    in_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
